// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the routing table engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define RTE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define RTE_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define RTE_ASSERT(lbl, clk, rstn, prop, msg)
`define RTE_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- rtl/rte_pkg.sv -----
// Shared constants, types and helper functions of the routing table engine.
`timescale 1ns / 1ps
package rte_pkg;

	localparam int TABLE_SIZE  = 32;
	localparam int ADDR_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
	localparam int DATA_W      = 8;
	localparam int CFG_ADDR_W  = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes on the input word.
	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_LEARN  = 3'd1;
	localparam logic [2:0] CMD_SUCC   = 3'd2;
	localparam logic [2:0] CMD_PRED   = 3'd3;
	localparam logic [2:0] CMD_DUMP   = 3'd4;

	// Status codes on the result word.
	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_REJECT  = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	// Configuration register indexes.
	localparam logic REG_OWN_ADDRESS = 1'b0;
	localparam logic REG_IS_GATEWAY  = 1'b1;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_STATUS,
		OP_SUCC,
		OP_PRED,
		OP_DUMP
	} op_t;

	// One classified command as it travels from the front end to the back end.
	typedef struct packed {
		op_t               op;
		logic [1:0]        status;
		logic [ADDR_W-1:0] index;
		logic [DATA_W-1:0] hops;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DUMP,
		ST_EMIT
	} state_t;

	// Mask with every entry above ptr set.
	function automatic logic [TABLE_SIZE-1:0] above_mask(input logic [ADDR_W-1:0] ptr);
		logic [TABLE_SIZE-1:0] m;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			m[i] = (i > int'(ptr));
		end
		return m;
	endfunction

	// Hop count plus one, saturating at the top of the field.
	function automatic logic [DATA_W-1:0] hops_inc(input logic [DATA_W-1:0] h);
		logic [DATA_W-1:0] r;
		r = (h == {DATA_W{1'b1}}) ? h : h + DATA_W'(1);
		return r;
	endfunction

endpackage

// ----- rtl/rte_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module rte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/rte_front.sv -----
// Front end: configuration registers and classification of input words.
`timescale 1ns / 1ps
module rte_front import rte_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            cmd,
	input  logic [DATA_W-1:0]     node_address,
	input  logic [DATA_W-1:0]     hop_count,
	input  logic                  q_full,
	output logic                  q_push,
	output cmd_t                  q_cmd
);

	logic [DATA_W-1:0] own_address_q;
	logic              is_gateway_q;
	logic              cfg_wr;
	logic              addr_ok;
	logic              in_range;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			is_gateway_q  <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_OWN_ADDRESS) begin
				own_address_q <= pwdata[DATA_W-1:0];
			end else begin
				is_gateway_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_OWN_ADDRESS) begin
			prdata[DATA_W-1:0] = own_address_q;
		end else begin
			prdata[0] = is_gateway_q;
		end
	end

	assign full   = q_full;
	assign q_push = push & ~q_full;

	assign in_range = (node_address < DATA_W'(TABLE_SIZE));
	assign addr_ok  = in_range && (node_address != '0);

	always_comb begin
		q_cmd.op     = OP_STATUS;
		q_cmd.status = STATUS_DONE;
		q_cmd.index  = node_address[ADDR_W-1:0];
		q_cmd.hops   = hop_count;
		case (cmd)
			CMD_UPDATE: begin
				if (addr_ok) begin
					q_cmd.op = OP_WRITE;
				end else begin
					q_cmd.status = STATUS_REJECT;
				end
			end
			CMD_LEARN: begin
				if (is_gateway_q || node_address == own_address_q) begin
					q_cmd.status = STATUS_IGNORED;
				end else if (addr_ok) begin
					q_cmd.op = OP_WRITE;
				end else begin
					q_cmd.status = STATUS_REJECT;
				end
			end
			CMD_SUCC: begin
				// A start past the table finds nothing, which is a plain done word.
				if (in_range) begin
					q_cmd.op = OP_SUCC;
				end
			end
			CMD_PRED: begin
				q_cmd.op = OP_PRED;
				if (!in_range) begin
					q_cmd.index = ADDR_W'(TABLE_SIZE - 1);
				end
			end
			CMD_DUMP: begin
				q_cmd.op = OP_DUMP;
			end
			default: begin
				q_cmd.status = STATUS_IGNORED;
			end
		endcase
	end

endmodule

// ----- rtl/rte_cmd_queue.sv -----
// Short queue of classified commands between the front and back ends.
`timescale 1ns / 1ps
module rte_cmd_queue import rte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign rdata   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/rte_back.sv -----
// Back end: hop table, entry count, search and dump sequencer, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rte_back import rte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] found_address,
	output logic [DATA_W-1:0] found_hops,
	output logic [DATA_W-1:0] entry_total,
	output logic              last_result
);

	state_t                state_q, state_d;
	logic [ADDR_W-1:0]     ptr_q, ptr_d;
	logic                  up_q, up_d;
	logic                  emit_last_q, emit_last_d;
	logic [TABLE_SIZE-1:0] valid_q, valid_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;

	logic                  out_valid_q;
	logic                  out_load;
	logic [1:0]            out_status;
	logic [DATA_W-1:0]     out_addr;
	logic [DATA_W-1:0]     out_hops;
	logic                  out_last;
	logic                  out_free;

	logic                  ram_we;
	logic                  ram_re;
	logic [DATA_W-1:0]     ram_rdata;
	logic                  hit;
	logic                  old_valid;
	logic                  hops_nz;

	rte_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_SIZE)
	) u_hop_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_cmd.index),
		.wdata(q_cmd.hops),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign out_free  = ~out_valid_q | pop;
	assign hit       = valid_q[ptr_q];
	assign old_valid = valid_q[q_cmd.index];
	assign hops_nz   = (q_cmd.hops != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q       <= ptr_d;
		up_q        <= up_d;
		emit_last_q <= emit_last_d;
		if (out_load) begin
			status        <= out_status;
			found_address <= out_addr;
			found_hops    <= out_hops;
			entry_total   <= DATA_W'(cnt_d);
			last_result   <= out_last;
		end
	end

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		up_d        = up_q;
		emit_last_d = emit_last_q;
		valid_d     = valid_q;
		cnt_d       = cnt_q;
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		out_load    = 1'b0;
		out_status  = STATUS_DONE;
		out_addr    = '0;
		out_hops    = '0;
		out_last    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						OP_WRITE: begin
							ram_we                = 1'b1;
							valid_d[q_cmd.index] = hops_nz;
							if (!old_valid && hops_nz) begin
								cnt_d = cnt_q + CNT_W'(1);
							end else if (old_valid && !hops_nz) begin
								cnt_d = cnt_q - CNT_W'(1);
							end
							out_load = 1'b1;
						end
						OP_SUCC, OP_PRED: begin
							ptr_d   = q_cmd.index;
							up_d    = (q_cmd.op == OP_SUCC);
							state_d = ST_SEARCH;
						end
						OP_DUMP: begin
							if (valid_q == '0) begin
								out_load = 1'b1;
							end else begin
								ptr_d   = ADDR_W'(1);
								state_d = ST_DUMP;
							end
						end
						default: begin
							out_status = q_cmd.status;
							out_load   = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (out_free) begin
					if (hit) begin
						out_addr = DATA_W'(ptr_q);
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else if (up_q && ptr_q == ADDR_W'(TABLE_SIZE - 1)) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else if (!up_q && ptr_q == '0) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else if (up_q) begin
						ptr_d = ptr_q + ADDR_W'(1);
					end else begin
						ptr_d = ptr_q - ADDR_W'(1);
					end
				end
			end
			ST_DUMP: begin
				if (!hit) begin
					ptr_d = ptr_q + ADDR_W'(1);
				end else if (out_free) begin
					ram_re      = 1'b1;
					emit_last_d = ((valid_q & above_mask(ptr_q)) == '0);
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// The result register was free when the read was issued.
				out_addr = DATA_W'(ptr_q);
				out_hops = hops_inc(ram_rdata);
				out_last = emit_last_q;
				out_load = 1'b1;
				if (emit_last_q) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d   = ptr_q + ADDR_W'(1);
					state_d = ST_DUMP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign empty = ~out_valid_q;

	`RTE_ASSERT(a_count_matches, clk, arst_n, cnt_q == CNT_W'($countones(valid_q)), "entry count out of step with valid bits")
	`RTE_ASSERT_NEVER(a_no_entry_zero, clk, arst_n, valid_q[0], "address zero marked valid")
	`RTE_ASSERT(a_no_overwrite, clk, arst_n, out_load |-> (!out_valid_q || pop), "result word overwritten before it was taken")
	`RTE_ASSERT(a_emit_valid, clk, arst_n, (state_q == ST_EMIT) |-> valid_q[ptr_q], "dump emitted an empty entry")

endmodule

// ----- rtl/routing_table_engine.sv -----
// Top level of the routing table engine: front end, command queue and back end.
`timescale 1ns / 1ps
//
//  Channel        Handshake                    Contents
//  -------------  ---------------------------  -----------------------------------------
//  input words    push / full                  cmd, node_address, hop_count
//  result words   empty / pop                  status, found_address, found_hops,
//                                              entry_total, last_result
//  configuration  psel / penable / pready      own_address at 0x0, is_gateway at 0x4
//
// An update, learn, rejected or unknown command is finished in the idle state as it is
// popped. A successor or predecessor search checks one table entry per cycle while the
// result register is free. A dump skips empty entries; it reads each valid entry in
// ST_DUMP and emits it in ST_EMIT, because the hop table RAM has a registered read port.
// Reset clears the per-entry valid bits at once, so there is no clearing pass.
// The two-word command queue lets the front end keep taking words while the back end
// waits on a full result register; only a dump's skipping of empty entries goes on then.
module routing_table_engine import rte_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Input words.
	input  logic                  push,
	output logic                  full,
	input  logic [2:0]            cmd,
	input  logic [DATA_W-1:0]     node_address,
	input  logic [DATA_W-1:0]     hop_count,
	// Result words.
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            status,
	output logic [DATA_W-1:0]     found_address,
	output logic [DATA_W-1:0]     found_hops,
	output logic [DATA_W-1:0]     entry_total,
	output logic                  last_result
);

	// Classified commands flow from the front end through the queue.
	logic q_full;
	logic q_push;
	cmd_t q_wdata;
	logic q_valid;
	logic q_pop;
	cmd_t q_rdata;

	// The front end holds the configuration registers and turns each input word into
	// a command the back end can execute without looking at the configuration again.
	rte_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.node_address(node_address),
		.hop_count   (hop_count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_wdata)
	);

	rte_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	// The back end owns the hop table and produces every result word.
	rte_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_rdata),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.found_address(found_address),
		.found_hops   (found_hops),
		.entry_total  (entry_total),
		.last_result  (last_result)
	);

endmodule
